// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg: shared types, widths and helpers
// Widths, register indexes, the edge result record and the saturating helpers
// used by the closest-point-on-ring block.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int CW   = 32;          // coordinate width, Q28.4
    localparam int EW   = CW + 1;      // edge vector / offset width
    localparam int MW   = CW + 3;      // multiplier operand width
    localparam int PW   = 2 * MW;      // multiplier product width
    localparam int L2W  = 2 * CW + 3;  // squared length / dot / distance
    localparam int BW   = 2 * CW + 4;  // best distance, division remainder
    localparam int LW   = CW + 2;      // edge length
    localparam int FB   = 30;          // projection fraction bits
    localparam int DW   = 16;          // direction width, Q1.15
    localparam int DQ   = DW + 1;      // direction quotient bits
    localparam int NW   = EW + DW;     // direction numerator width
    localparam int AW   = 40;          // arc width, Q36.4
    localparam int CNTW = $clog2(LW);

    localparam logic [L2W-1:0] MIN_LEN2 = L2W'(256);
    localparam logic signed [DW-1:0] DIR_ONE = DW'((1 << (DW - 1)) - 1);

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_QUERY_X = 2'd0;
    localparam t_reg_idx REG_QUERY_Y = 2'd1;

    typedef struct packed {
        logic                  done;
        logic                  ok;
        logic [L2W-1:0]        d2;
        logic signed [CW-1:0]  px;
        logic signed [CW-1:0]  py;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic [LW-1:0]         len;
        logic [LW-1:0]         part;
    } t_edge_res;

    function automatic logic [AW-1:0] arc_add(input logic [AW-1:0] a,
                                              input logic [LW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (AW + 1)'(b);
        return s[AW] ? {AW{1'b1}} : s[AW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] dir_sat(input logic neg,
                                                     input logic [DQ-1:0] q);
        logic [DQ-1:0] lim;
        logic [DQ-1:0] m;
        logic [DQ-1:0] r;
        lim = neg ? (DQ'(1) << (DW - 1)) : ((DQ'(1) << (DW - 1)) - DQ'(1));
        m   = (q > lim) ? lim : q;
        r   = neg ? (~m + DQ'(1)) : m;
        return r[DW-1:0];
    endfunction

endpackage

// ===== rtl/cpr_in_if.sv =====
// ----------------------------------------------------------------------------
// cpr_in_if: vertex channel
// Valid/ready channel carrying one ring vertex per beat.
// ----------------------------------------------------------------------------
interface cpr_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [cpr_pkg::CW-1:0] vertex_x;
    logic signed [cpr_pkg::CW-1:0] vertex_y;
    logic                          last_vertex;

    modport source(output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink(input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// ===== rtl/cpr_out_if.sv =====
// ----------------------------------------------------------------------------
// cpr_out_if: result channel
// Valid/ready channel carrying one closest-point result per beat.
// ----------------------------------------------------------------------------
interface cpr_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [cpr_pkg::CW-1:0] closest_x;
    logic signed [cpr_pkg::CW-1:0] closest_y;
    logic signed [cpr_pkg::DW-1:0] edge_dir_x;
    logic signed [cpr_pkg::DW-1:0] edge_dir_y;
    logic [cpr_pkg::AW-1:0]        arc_to_point;
    logic                          no_usable_edge;

    modport source(output valid, closest_x, closest_y, edge_dir_x, edge_dir_y,
                   arc_to_point, no_usable_edge, input ready);
    modport sink(input valid, closest_x, closest_y, edge_dir_x, edge_dir_y,
                 arc_to_point, no_usable_edge, output ready);
endinterface

// ===== rtl/cpr_mul.sv =====
// ----------------------------------------------------------------------------
// cpr_mul: shared signed multiplier
// One signed multiply with a registered product, reused by the edge sequencer.
// ----------------------------------------------------------------------------
module cpr_mul (
    input  logic                              i_clk,
    input  logic signed [cpr_pkg::MW-1:0]     i_a,
    input  logic signed [cpr_pkg::MW-1:0]     i_b,
    output logic signed [cpr_pkg::PW-1:0]     o_p
);

    logic signed [cpr_pkg::PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/cpr_edge.sv =====
// ----------------------------------------------------------------------------
// cpr_edge: single edge evaluator
// Sequencer around the shared multiplier, a one-bit-per-cycle divider and a
// two-bit-per-cycle square root: clamped projection, closest point, squared
// distance, length, arc part and unit direction of one edge.
// ----------------------------------------------------------------------------
module cpr_edge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [cpr_pkg::CW-1:0]     i_ax,
    input  logic signed [cpr_pkg::CW-1:0]     i_ay,
    input  logic signed [cpr_pkg::CW-1:0]     i_bx,
    input  logic signed [cpr_pkg::CW-1:0]     i_by,
    input  logic signed [cpr_pkg::CW-1:0]     i_qx,
    input  logic signed [cpr_pkg::CW-1:0]     i_qy,
    output cpr_pkg::t_edge_res                o_res
);

    typedef enum logic [17:0] {
        E_IDLE  = 18'h00001,
        E_LENA  = 18'h00002,
        E_LENB  = 18'h00004,
        E_DOTA  = 18'h00008,
        E_DOTB  = 18'h00010,
        E_TSEL  = 18'h00020,
        E_TDIV  = 18'h00040,
        E_MX    = 18'h00080,
        E_MY    = 18'h00100,
        E_PY    = 18'h00200,
        E_D2A   = 18'h00400,
        E_D2B   = 18'h00800,
        E_SQRT  = 18'h01000,
        E_PART  = 18'h02000,
        E_PARTW = 18'h04000,
        E_DIRX  = 18'h08000,
        E_DIRY  = 18'h10000,
        E_DONE  = 18'h20000
    } t_estate;

    t_estate                          r_state;
    logic signed [cpr_pkg::CW-1:0]    r_ax, r_ay, r_px, r_py;
    logic signed [cpr_pkg::EW-1:0]    r_ex, r_ey, r_wx, r_wy;
    logic signed [cpr_pkg::L2W-1:0]   r_acc;
    logic [cpr_pkg::L2W-1:0]          r_len2;
    logic [cpr_pkg::FB:0]             r_t;
    logic [cpr_pkg::BW-1:0]           r_div_r;
    logic [cpr_pkg::L2W-1:0]          r_div_d;
    logic [cpr_pkg::DQ-1:0]           r_div_n;
    logic [cpr_pkg::FB-1:0]           r_div_q;
    logic [cpr_pkg::BW-1:0]           r_sq_src;
    logic [cpr_pkg::LW+3:0]           r_sq_rem;
    logic [cpr_pkg::LW-1:0]           r_sq_root;
    logic [cpr_pkg::CNTW-1:0]         r_cnt;
    cpr_pkg::t_edge_res               r_res;

    logic signed [cpr_pkg::MW-1:0]    w_a, w_b;
    logic signed [cpr_pkg::PW-1:0]    w_p;
    logic [cpr_pkg::EW-1:0]           w_exm, w_eym;
    logic signed [cpr_pkg::EW-1:0]    w_dqx, w_dqy;
    logic signed [cpr_pkg::L2W-1:0]   w_sum;
    logic [cpr_pkg::PW-1:0]           w_rnd;
    logic [cpr_pkg::EW-1:0]           w_mag;
    logic [cpr_pkg::LW-1:0]           w_part;
    logic signed [cpr_pkg::CW+1:0]    w_off, w_pxs, w_pys;
    logic [cpr_pkg::BW-1:0]           w_div_rs, w_div_rn;
    logic                             w_div_ge;
    logic [cpr_pkg::FB-1:0]           w_div_qn;
    logic [cpr_pkg::LW+3:0]           w_sq_rs, w_sq_tr, w_sq_rn;
    logic                             w_sq_ge;
    logic [cpr_pkg::LW-1:0]           w_sq_rootn;
    logic [cpr_pkg::NW-1:0]           w_num;

    cpr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    assign w_exm = r_ex[cpr_pkg::EW-1] ? cpr_pkg::EW'(-r_ex) : cpr_pkg::EW'(r_ex);
    assign w_eym = r_ey[cpr_pkg::EW-1] ? cpr_pkg::EW'(-r_ey) : cpr_pkg::EW'(r_ey);
    assign w_dqx = cpr_pkg::EW'(r_px) - cpr_pkg::EW'(i_qx);
    assign w_dqy = cpr_pkg::EW'(r_py) - cpr_pkg::EW'(i_qy);
    assign w_sum = r_acc + cpr_pkg::L2W'(w_p);

    // round half up on the non-negative products |e|*t and len*t
    assign w_rnd  = $unsigned(w_p) + (cpr_pkg::PW'(1) << (cpr_pkg::FB - 1));
    assign w_mag  = w_rnd[cpr_pkg::FB+cpr_pkg::EW-1:cpr_pkg::FB];
    assign w_part = w_rnd[cpr_pkg::FB+cpr_pkg::LW-1:cpr_pkg::FB];
    assign w_off  = (cpr_pkg::CW + 2)'($signed({1'b0, w_mag}));
    assign w_pxs  = (cpr_pkg::CW + 2)'(r_ax) + (r_ex[cpr_pkg::EW-1] ? -w_off : w_off);
    assign w_pys  = (cpr_pkg::CW + 2)'(r_ay) + (r_ey[cpr_pkg::EW-1] ? -w_off : w_off);

    assign w_div_rs = {r_div_r[cpr_pkg::BW-2:0], r_div_n[cpr_pkg::DQ-1]};
    assign w_div_ge = w_div_rs >= cpr_pkg::BW'(r_div_d);
    assign w_div_rn = w_div_ge ? (w_div_rs - cpr_pkg::BW'(r_div_d)) : w_div_rs;
    assign w_div_qn = {r_div_q[cpr_pkg::FB-2:0], w_div_ge};

    assign w_sq_rs    = {r_sq_rem[cpr_pkg::LW+1:0], r_sq_src[cpr_pkg::BW-1:cpr_pkg::BW-2]};
    assign w_sq_tr    = (cpr_pkg::LW + 4)'({r_sq_root, 2'b01});
    assign w_sq_ge    = w_sq_rs >= w_sq_tr;
    assign w_sq_rn    = w_sq_ge ? (w_sq_rs - w_sq_tr) : w_sq_rs;
    assign w_sq_rootn = {r_sq_root[cpr_pkg::LW-2:0], w_sq_ge};

    // direction numerator: (|e| << 15) + len/2
    assign w_num = (cpr_pkg::NW'(r_state == E_PARTW ? w_exm : w_eym) << (cpr_pkg::DW - 1))
                   + cpr_pkg::NW'(r_res.len >> 1);

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            E_LENA: begin
                w_a = cpr_pkg::MW'(r_ex);
                w_b = cpr_pkg::MW'(r_ex);
            end
            E_LENB: begin
                w_a = cpr_pkg::MW'(r_ey);
                w_b = cpr_pkg::MW'(r_ey);
            end
            E_DOTA: begin
                w_a = cpr_pkg::MW'(r_wx);
                w_b = cpr_pkg::MW'(r_ex);
            end
            E_DOTB: begin
                w_a = cpr_pkg::MW'(r_wy);
                w_b = cpr_pkg::MW'(r_ey);
            end
            E_MX: begin
                w_a = cpr_pkg::MW'($signed({1'b0, w_exm}));
                w_b = cpr_pkg::MW'($signed({1'b0, r_t}));
            end
            E_MY: begin
                w_a = cpr_pkg::MW'($signed({1'b0, w_eym}));
                w_b = cpr_pkg::MW'($signed({1'b0, r_t}));
            end
            E_PY: begin
                w_a = cpr_pkg::MW'(w_dqx);
                w_b = cpr_pkg::MW'(w_dqx);
            end
            E_D2A: begin
                w_a = cpr_pkg::MW'(w_dqy);
                w_b = cpr_pkg::MW'(w_dqy);
            end
            E_PART: begin
                w_a = cpr_pkg::MW'($signed({1'b0, r_res.len}));
                w_b = cpr_pkg::MW'($signed({1'b0, r_t}));
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_res   <= '0;
        end else begin
            r_res.done <= 1'b0;
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_ax    <= i_ax;
                        r_ay    <= i_ay;
                        r_ex    <= cpr_pkg::EW'(i_bx) - cpr_pkg::EW'(i_ax);
                        r_ey    <= cpr_pkg::EW'(i_by) - cpr_pkg::EW'(i_ay);
                        r_wx    <= cpr_pkg::EW'(i_qx) - cpr_pkg::EW'(i_ax);
                        r_wy    <= cpr_pkg::EW'(i_qy) - cpr_pkg::EW'(i_ay);
                        r_state <= E_LENA;
                    end
                end
                E_LENA: r_state <= E_LENB;
                E_LENB: begin
                    r_acc   <= cpr_pkg::L2W'(w_p);
                    r_state <= E_DOTA;
                end
                E_DOTA: begin
                    r_len2  <= $unsigned(w_sum);
                    r_state <= E_DOTB;
                end
                E_DOTB: begin
                    r_acc <= cpr_pkg::L2W'(w_p);
                    if (r_len2 < cpr_pkg::MIN_LEN2) begin
                        r_res.ok <= 1'b0;
                        r_state  <= E_DONE;
                    end else begin
                        r_res.ok <= 1'b1;
                        r_state  <= E_TSEL;
                    end
                end
                E_TSEL: begin
                    if (w_sum[cpr_pkg::L2W-1] || w_sum == '0) begin
                        r_t     <= '0;
                        r_state <= E_MX;
                    end else if ($unsigned(w_sum) >= r_len2) begin
                        r_t     <= (cpr_pkg::FB + 1)'(1) << cpr_pkg::FB;
                        r_state <= E_MX;
                    end else begin
                        r_div_r <= cpr_pkg::BW'($unsigned(w_sum));
                        r_div_d <= r_len2;
                        r_div_n <= '0;
                        r_cnt   <= cpr_pkg::CNTW'(cpr_pkg::FB - 1);
                        r_state <= E_TDIV;
                    end
                end
                E_TDIV: begin
                    r_div_r <= w_div_rn;
                    r_div_q <= w_div_qn;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_t     <= {1'b0, w_div_qn};
                        r_state <= E_MX;
                    end
                end
                E_MX: r_state <= E_MY;
                E_MY: begin
                    r_px    <= w_pxs[cpr_pkg::CW-1:0];
                    r_state <= E_PY;
                end
                E_PY: begin
                    r_py    <= w_pys[cpr_pkg::CW-1:0];
                    r_state <= E_D2A;
                end
                E_D2A: begin
                    r_acc   <= cpr_pkg::L2W'(w_p);
                    r_state <= E_D2B;
                end
                E_D2B: begin
                    r_res.d2  <= $unsigned(w_sum);
                    r_res.px  <= r_px;
                    r_res.py  <= r_py;
                    r_sq_src  <= cpr_pkg::BW'(r_len2);
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= cpr_pkg::CNTW'(cpr_pkg::LW - 1);
                    r_state   <= E_SQRT;
                end
                E_SQRT: begin
                    r_sq_src  <= {r_sq_src[cpr_pkg::BW-3:0], 2'b00};
                    r_sq_rem  <= w_sq_rn;
                    r_sq_root <= w_sq_rootn;
                    r_cnt     <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_res.len <= w_sq_rootn;
                        r_state   <= E_PART;
                    end
                end
                E_PART: r_state <= E_PARTW;
                E_PARTW: begin
                    r_res.part <= w_part;
                    r_div_r    <= cpr_pkg::BW'(w_num[cpr_pkg::NW-1:cpr_pkg::DQ]);
                    r_div_n    <= w_num[cpr_pkg::DQ-1:0];
                    r_div_d    <= cpr_pkg::L2W'(r_res.len);
                    r_cnt      <= cpr_pkg::CNTW'(cpr_pkg::DQ - 1);
                    r_state    <= E_DIRX;
                end
                E_DIRX: begin
                    r_div_r <= w_div_rn;
                    r_div_q <= w_div_qn;
                    r_div_n <= {r_div_n[cpr_pkg::DQ-2:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_res.dx <= cpr_pkg::dir_sat(r_ex[cpr_pkg::EW-1],
                                                     w_div_qn[cpr_pkg::DQ-1:0]);
                        r_div_r  <= cpr_pkg::BW'(w_num[cpr_pkg::NW-1:cpr_pkg::DQ]);
                        r_div_n  <= w_num[cpr_pkg::DQ-1:0];
                        r_cnt    <= cpr_pkg::CNTW'(cpr_pkg::DQ - 1);
                        r_state  <= E_DIRY;
                    end
                end
                E_DIRY: begin
                    r_div_r <= w_div_rn;
                    r_div_q <= w_div_qn;
                    r_div_n <= {r_div_n[cpr_pkg::DQ-2:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_res.dy <= cpr_pkg::dir_sat(r_ey[cpr_pkg::EW-1],
                                                     w_div_qn[cpr_pkg::DQ-1:0]);
                        r_state  <= E_DONE;
                    end
                end
                E_DONE: begin
                    r_res.done <= 1'b1;
                    r_state    <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/closest_point_on_ring_top.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_ring_top: closest point on a closed ring to a query point
// Vertices arrive one beat at a time; the query point sits in two registers.
// The block keeps the nearest clamped point over all edges of length at least
// 1.0 in Q28.4 units, its Q1.15 edge direction and the arc to it, measured from
// the last vertex with the closing edge first, and emits one result beat after
// the last vertex (which also closes the ring). One edge evaluator is reused
// for every edge: a usable edge runs the 30-step fraction division (skipped
// when the projection clamps), the 34-step square root and two 17-step
// direction divisions, a too-short edge none of them. A last vertex also
// starts the closing edge. Input is not ready while an item is in work; a
// finished result waits in the output register.
// ----------------------------------------------------------------------------
module closest_point_on_ring_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  cpr_pkg::t_reg_idx             i_cfg_idx,
    input  logic [cpr_pkg::CW-1:0]        i_cfg_data,
    cpr_in_if.sink                        i_in,
    cpr_out_if.source                     o_out
);

    typedef enum logic [5:0] {
        T_IDLE = 6'b000001,
        T_E1   = 6'b000010,
        T_W1   = 6'b000100,
        T_E2   = 6'b001000,
        T_W2   = 6'b010000,
        T_FIN  = 6'b100000
    } t_tstate;

    t_tstate                          r_state;
    logic signed [cpr_pkg::CW-1:0]    r_qx, r_qy;
    logic signed [cpr_pkg::CW-1:0]    r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [cpr_pkg::CW-1:0]    r_vx, r_vy;
    logic                             r_last, r_have_prev, r_any;
    logic [cpr_pkg::BW-1:0]           r_best_d2;
    logic signed [cpr_pkg::CW-1:0]    r_best_px, r_best_py;
    logic signed [cpr_pkg::DW-1:0]    r_best_dx, r_best_dy;
    logic [cpr_pkg::AW-1:0]           r_best_arc, r_arc_sum;

    logic                             r_o_valid, r_o_no_use;
    logic signed [cpr_pkg::CW-1:0]    r_o_x, r_o_y;
    logic signed [cpr_pkg::DW-1:0]    r_o_dx, r_o_dy;
    logic [cpr_pkg::AW-1:0]           r_o_arc;

    logic                             w_start, w_load;
    logic signed [cpr_pkg::CW-1:0]    w_ax, w_ay, w_bx, w_by;
    cpr_pkg::t_edge_res               w_res;
    logic [cpr_pkg::BW-1:0]           w_d2;

    assign w_start = (r_state == T_E1 && r_have_prev) || r_state == T_E2;
    assign w_load  = (r_state == T_FIN) && (!r_o_valid || o_out.ready);
    assign w_d2    = cpr_pkg::BW'(w_res.d2);

    always_comb begin
        if (r_state == T_E2) begin
            w_ax = r_vx;
            w_ay = r_vy;
            w_bx = r_first_x;
            w_by = r_first_y;
        end else begin
            w_ax = r_prev_x;
            w_ay = r_prev_y;
            w_bx = r_vx;
            w_by = r_vy;
        end
    end

    cpr_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpr_pkg::REG_QUERY_X: r_qx <= i_cfg_data;
                cpr_pkg::REG_QUERY_Y: r_qy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load) begin
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_any       <= 1'b0;
            r_best_d2   <= '1;
            r_best_px   <= '0;
            r_best_py   <= '0;
            r_best_dx   <= cpr_pkg::DIR_ONE;
            r_best_dy   <= '0;
            r_best_arc  <= '0;
            r_arc_sum   <= '0;
        end else begin
            case (r_state)
                T_E1: begin
                    if (!r_have_prev) begin
                        r_first_x <= r_vx;
                        r_first_y <= r_vy;
                    end
                    r_prev_x    <= r_vx;
                    r_prev_y    <= r_vy;
                    r_have_prev <= 1'b1;
                end
                T_W1: begin
                    if (w_res.done && w_res.ok) begin
                        if (w_d2 < r_best_d2) begin
                            r_best_d2  <= w_d2;
                            r_best_px  <= w_res.px;
                            r_best_py  <= w_res.py;
                            r_best_dx  <= w_res.dx;
                            r_best_dy  <= w_res.dy;
                            r_best_arc <= cpr_pkg::arc_add(r_arc_sum, w_res.part);
                        end
                        r_arc_sum <= cpr_pkg::arc_add(r_arc_sum, w_res.len);
                        r_any     <= 1'b1;
                    end
                end
                T_W2: begin
                    if (w_res.done && w_res.ok) begin
                        // closing edge counts as the first edge and wins ties
                        if (!r_any || w_d2 <= r_best_d2) begin
                            r_best_d2  <= w_d2;
                            r_best_px  <= w_res.px;
                            r_best_py  <= w_res.py;
                            r_best_dx  <= w_res.dx;
                            r_best_dy  <= w_res.dy;
                            r_best_arc <= cpr_pkg::arc_add('0, w_res.part);
                        end else begin
                            r_best_arc <= cpr_pkg::arc_add(r_best_arc, w_res.len);
                        end
                        r_any <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (i_in.valid) begin
                        r_vx    <= i_in.vertex_x;
                        r_vy    <= i_in.vertex_y;
                        r_last  <= i_in.last_vertex;
                        r_state <= T_E1;
                    end
                end
                T_E1: begin
                    if (r_have_prev) begin
                        r_state <= T_W1;
                    end else begin
                        r_state <= r_last ? T_E2 : T_IDLE;
                    end
                end
                T_W1: begin
                    if (w_res.done) begin
                        r_state <= r_last ? T_E2 : T_IDLE;
                    end
                end
                T_E2: r_state <= T_W2;
                T_W2: begin
                    if (w_res.done) begin
                        r_state <= T_FIN;
                    end
                end
                T_FIN: begin
                    if (w_load) begin
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_any) begin
                r_o_x      <= r_best_px;
                r_o_y      <= r_best_py;
                r_o_dx     <= r_best_dx;
                r_o_dy     <= r_best_dy;
                r_o_arc    <= r_best_arc;
                r_o_no_use <= 1'b0;
            end else begin
                r_o_x      <= r_first_x;
                r_o_y      <= r_first_y;
                r_o_dx     <= cpr_pkg::DIR_ONE;
                r_o_dy     <= '0;
                r_o_arc    <= '0;
                r_o_no_use <= 1'b1;
            end
        end
    end

    assign i_in.ready           = (r_state == T_IDLE);
    assign o_out.valid          = r_o_valid;
    assign o_out.closest_x      = r_o_x;
    assign o_out.closest_y      = r_o_y;
    assign o_out.edge_dir_x     = r_o_dx;
    assign o_out.edge_dir_y     = r_o_dy;
    assign o_out.arc_to_point   = r_o_arc;
    assign o_out.no_usable_edge = r_o_no_use;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (r_state == T_W1 || r_state == T_W2))
        else $error("edge result outside a wait state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == T_E1))
        else $error("accepted beat did not start work");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (!r_have_prev && !r_any && r_o_valid))
        else $error("ring state not cleared after result");

    a_no_use_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_no_use) |-> (r_o_arc == '0 && r_o_dx == cpr_pkg::DIR_ONE))
        else $error("no-usable-edge result not at defaults");

endmodule

// ===== dv/closest_point_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// closest_point_checker: result predictor and comparator for the ring block
// Watches the query registers and the vertex and result channels, computes
// the closest ring point, edge direction and arc for every completed ring,
// and compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module closest_point_checker
    import cpr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  t_reg_idx        i_cfg_idx,
    input  logic [CW-1:0]   i_cfg_data,
    cpr_in_if               in_mon,
    cpr_out_if              out_mon,
    output int              o_fail_cnt,
    output int              o_pending
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        bit                   ok;
        wide_t                d2;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        wide_t                len;
        wide_t                part;
    } seg_eval_t;

    typedef struct {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [AW-1:0]        arc;
        logic                 none;
    } ring_result_t;

    localparam wide_t ARC_LIMIT = (wide_t'(1) <<< AW) - 1;
    localparam wide_t HALF_FRAC = wide_t'(1) <<< (FB - 1);

    logic signed [CW-1:0] qry_x, qry_y;
    logic signed [CW-1:0] first_x, first_y, prev_x, prev_y;
    bit                   have_prev, any_seg;
    logic [127:0]         best_d2;
    logic signed [CW-1:0] best_x, best_y;
    logic signed [DW-1:0] best_dx, best_dy;
    logic [AW-1:0]        best_arc, arc_sum;
    ring_result_t         expected_q[$];
    int                   fail_cnt;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = expected_q.size();

    function automatic wide_t absw(wide_t v);
        return v < 0 ? -v : v;
    endfunction

    function automatic wide_t isqrt(wide_t n);
        wide_t r;
        wide_t c;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (wide_t'(1) <<< b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] unit_comp(wide_t e, wide_t ln);
        wide_t q;
        q = ((absw(e) <<< 15) + (ln >>> 1)) / ln;
        if (e < 0) begin
            if (q > 32768) q = 32768;
            q = -q;
        end else if (q > 32767) begin
            q = 32767;
        end
        return q[DW-1:0];
    endfunction

    function automatic logic [AW-1:0] arc_sat(logic [AW-1:0] a, wide_t b);
        wide_t s;
        s = wide_t'({88'd0, a}) + b;
        return s > ARC_LIMIT ? ARC_LIMIT[AW-1:0] : s[AW-1:0];
    endfunction

    function automatic seg_eval_t eval_seg(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        seg_eval_t r;
        wide_t ex, ey, len2, dot, t, mx, my, px, py, qx, qy;
        r.ok = 0; r.d2 = 0; r.px = 0; r.py = 0; r.dx = 0; r.dy = 0; r.len = 0; r.part = 0;
        qx = qry_x;
        qy = qry_y;
        ex = bx - ax;
        ey = by - ay;
        len2 = ex * ex + ey * ey;
        if (len2 < 256) return r;
        r.ok = 1;
        dot = (qx - ax) * ex + (qy - ay) * ey;
        if (dot <= 0) t = 0;
        else if (dot >= len2) t = wide_t'(1) <<< FB;
        else t = (dot <<< FB) / len2;
        mx = (absw(ex) * t + HALF_FRAC) >>> FB;
        my = (absw(ey) * t + HALF_FRAC) >>> FB;
        px = ex < 0 ? ax - mx : ax + mx;
        py = ey < 0 ? ay - my : ay + my;
        r.px = px[CW-1:0];
        r.py = py[CW-1:0];
        r.d2 = (px - qx) * (px - qx) + (py - qy) * (py - qy);
        r.len = isqrt(len2);
        r.dx = unit_comp(ex, r.len);
        r.dy = unit_comp(ey, r.len);
        r.part = (r.len * t + HALF_FRAC) >>> FB;
        return r;
    endfunction

    task automatic clear_ring();
        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
        have_prev = 0;
        any_seg = 0;
        best_d2 = '1;
        best_x = 0; best_y = 0;
        best_dx = DIR_ONE; best_dy = 0;
        best_arc = 0;
        arc_sum = 0;
    endtask

    task automatic take_best(seg_eval_t s, logic [AW-1:0] arc);
        best_d2 = s.d2;
        best_x = s.px; best_y = s.py;
        best_dx = s.dx; best_dy = s.dy;
        best_arc = arc;
    endtask

    task automatic accept_vertex(logic signed [CW-1:0] vx, logic signed [CW-1:0] vy,
                                 logic last);
        seg_eval_t s;
        ring_result_t res;
        if (!have_prev) begin
            first_x = vx;
            first_y = vy;
        end else begin
            s = eval_seg(prev_x, prev_y, vx, vy);
            if (s.ok) begin
                if (s.d2 < best_d2) take_best(s, arc_sat(arc_sum, s.part));
                arc_sum = arc_sat(arc_sum, s.len);
                any_seg = 1;
            end
        end
        prev_x = vx;
        prev_y = vy;
        have_prev = 1;
        if (!last) return;
        // closing edge counts first along the arc and wins ties
        s = eval_seg(vx, vy, first_x, first_y);
        if (s.ok) begin
            if (!any_seg || s.d2 <= best_d2) take_best(s, arc_sat('0, s.part));
            else best_arc = arc_sat(best_arc, s.len);
            any_seg = 1;
        end
        if (!any_seg) begin
            res = '{first_x, first_y, DIR_ONE, '0, '0, 1'b1};
        end else begin
            res = '{best_x, best_y, best_dx, best_dy, best_arc, 1'b0};
        end
        expected_q.push_back(res);
        clear_ring();
    endtask

    initial begin
        fail_cnt = 0;
        qry_x = 0;
        qry_y = 0;
        clear_ring();
    end

    always @(posedge i_clk) begin
        ring_result_t exp_r;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_QUERY_X) qry_x = i_cfg_data;
                else if (i_cfg_idx == REG_QUERY_Y) qry_y = i_cfg_data;
            end
            if (in_mon.valid && in_mon.ready)
                accept_vertex(in_mon.vertex_x, in_mon.vertex_y, in_mon.last_vertex);
            if (out_mon.valid && out_mon.ready) begin
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: result beat with no ring pending", $realtime);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (out_mon.closest_x !== exp_r.cx || out_mon.closest_y !== exp_r.cy
                        || out_mon.edge_dir_x !== exp_r.dx || out_mon.edge_dir_y !== exp_r.dy
                        || out_mon.arc_to_point !== exp_r.arc
                        || out_mon.no_usable_edge !== exp_r.none) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("%0t: mismatch exp pt=(%0d,%0d) dir=(%0d,%0d) arc=%0d none=%0b"
                                     , $realtime, exp_r.cx, exp_r.cy, exp_r.dx, exp_r.dy,
                                     exp_r.arc, exp_r.none);
                        if (fail_cnt <= 10)
                            $display("          got pt=(%0d,%0d) dir=(%0d,%0d) arc=%0d none=%0b",
                                     out_mon.closest_x, out_mon.closest_y,
                                     out_mon.edge_dir_x, out_mon.edge_dir_y,
                                     out_mon.arc_to_point, out_mon.no_usable_edge);
                    end
                end
            end
        end
    end

endmodule

// ===== dv/closest_point_on_ring_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// closest_point_on_ring_top_tb: stimulus and verdict for the ring block
// Sends directed and random rings under several query points, including the
// coordinate extremes, with bursty vertex beats and a stalling result sink.
// The checker predicts and compares; a watchdog catches a hung block.
// ----------------------------------------------------------------------------
module closest_point_on_ring_top_tb;
    import cpr_pkg::*;

    localparam int       WATCHDOG_LIMIT = 20000;
    localparam int       SETTLE_CYCLES  = 300;
    localparam int       RANDOM_ITEMS   = 1150;
    localparam t_reg_idx REG_SPARE      = 2'd3;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_reg_idx             cfg_idx;
    logic [CW-1:0]        cfg_data;
    int                   fail_cnt;
    int                   pending;
    int                   burst_left;
    int                   items_sent;
    int                   stall_mode;
    int                   idle_cycles;
    logic signed [CW-1:0] cur_qx, cur_qy;

    cpr_in_if  vtx_if();
    cpr_out_if res_if();

    always #5 i_clk = ~i_clk;

    closest_point_on_ring_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (vtx_if),
        .o_out      (res_if)
    );

    closest_point_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_mon     (vtx_if),
        .out_mon    (res_if),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    // result sink stall pattern
    always @(posedge i_clk) begin
        if ($urandom_range(0, 149) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: begin
                res_if.ready <= 1'b1;
            end
            1: begin
                res_if.ready <= $urandom_range(0, 1);
            end
            default: begin
                res_if.ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                vtx_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        vtx_if.valid       <= 1'b1;
        vtx_if.vertex_x    <= x;
        vtx_if.vertex_y    <= y;
        vtx_if.last_vertex <= last;
        @(posedge i_clk);
        while (!vtx_if.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic drain();
        vtx_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_query(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        drain();
        write_reg(REG_QUERY_X, x);
        write_reg(REG_QUERY_Y, y);
        write_reg(REG_SPARE, $urandom);
        cfg_we <= 1'b0;
        cur_qx = x;
        cur_qy = y;
    endtask

    function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] ctr);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return ctr + $signed(CW'($urandom_range(0, 64))) - 32;
            4, 5, 6:    return ctr + $signed(CW'($signed(16'($urandom))));
            7:          return ctr + $signed(CW'($signed(24'($urandom))));
            8:          return $urandom;
            default:    return $urandom_range(0, 1) ? C_MAX : C_MIN;
        endcase
    endfunction

    task automatic random_ring();
        int n;
        logic signed [CW-1:0] cx, cy;
        cx = $urandom_range(0, 2) ? cur_qx : CW'($urandom);
        cy = $urandom_range(0, 2) ? cur_qy : CW'($urandom);
        if ($urandom_range(0, 59) == 0) begin
            // long ring of corner-to-corner edges builds a large arc without reaching saturation
            n = $urandom_range(100, 140);
            for (int i = 0; i < n; i++)
                send_vertex(i[0] ? C_MAX : C_MIN, i[1] ? C_MIN : C_MAX, i == n - 1);
        end else begin
            n = $urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
                send_vertex(pick_coord(cx), pick_coord(cy), i == n - 1);
        end
    endtask

    task automatic directed_rings();
        send_vertex(5, -7, 1'b1);
        send_vertex(48, 48, 1'b0);
        send_vertex(48, 48, 1'b0);
        send_vertex(48, 48, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(15, 0, 1'b0);
        send_vertex(15, 15, 1'b1);
        send_vertex(-160, -160, 1'b0);
        send_vertex(160, -160, 1'b0);
        send_vertex(160, 160, 1'b0);
        send_vertex(-160, 160, 1'b1);
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MIN, 1'b1);
        send_vertex(320, 0, 1'b0);
        send_vertex(640, 0, 1'b1);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_QUERY_X;
        cfg_data           = '0;
        vtx_if.valid       = 1'b0;
        vtx_if.vertex_x    = '0;
        vtx_if.vertex_y    = '0;
        vtx_if.last_vertex = 1'b0;
        res_if.ready       = 1'b0;
        stall_mode         = 0;
        idle_cycles        = 0;
        burst_left         = 0;
        items_sent         = 0;
        cur_qx             = 0;
        cur_qy             = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_rings();
        set_query(C_MAX, C_MAX);
        directed_rings();
        set_query(C_MIN, C_MIN);
        directed_rings();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_query(0, 0);
                1: set_query(C_MAX, C_MIN);
                2: set_query(C_MIN, C_MAX);
                default: set_query($urandom, $urandom);
            endcase
            while (items_sent < (phase + 1) * RANDOM_ITEMS / 6 + 48) random_ring();
        end

        drain();
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpr_pkg.sv
rtl/cpr_in_if.sv
rtl/cpr_out_if.sv
rtl/cpr_mul.sv
rtl/cpr_edge.sv
rtl/closest_point_on_ring_top.sv
dv/closest_point_checker.sv
dv/closest_point_on_ring_top_tb.sv
